FILE: hdl/hft_pkg.sv
// shared types and constants for the huffman tree loader and decoder
// no dependencies; used by the top level, the ram wrapper users and the checker
package hft_pkg;

    localparam int MAX_NODES   = 512;
    localparam int STACK_DEPTH = 256;

    // index widths and counter widths (counters also hold the full depth)
    localparam int NODE_IW = $clog2(MAX_NODES);
    localparam int NODE_CW = $clog2(MAX_NODES + 1);
    localparam int STK_IW  = $clog2(STACK_DEPTH);
    localparam int STK_CW  = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_LEAF   = 8'h4C;
    localparam logic [7:0] CH_BRANCH = 8'h42;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;

    typedef enum logic [1:0] {
        CMD_TREE = 2'd0,
        CMD_END  = 2'd1,
        CMD_CODE = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PEND_NONE   = 2'd0,
        PEND_BRANCH = 2'd1,
        PEND_CODE   = 2'd2
    } t_pend;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] symbol;
        logic       status;
    } t_out_item;

    typedef struct packed {
        logic               leaf;
        logic [7:0]         sym;
        logic [NODE_IW-1:0] left;
        logic [NODE_IW-1:0] right;
    } t_node;

endpackage

FILE: hdl/hft_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module hft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/huffman_tree_load_and_decode.sv
// huffman tree loader and decoder: node table and node stack in hft_ram instances.
// results are registered in the output queue; '0'/'1' code items wait for the node
// table read before their result is queued.
// throughput: one item per cycle; branches and code bits stall the input for their
// table or stack read, and while both output slots are taken the input stalls too.
// reset: synchronous, clears control state only, no clear pass.
module huffman_tree_load_and_decode
    import hft_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    t_pend              r_pend, n_pend;
    logic [STK_CW-1:0]  r_sp, n_sp;
    logic [NODE_CW-1:0] r_nc, n_nc;
    logic               r_exp, n_exp;
    logic               r_ready, n_ready;
    t_node              r_top, n_top;
    t_node              r_cur, n_cur;
    t_node              r_root, n_root;

    t_out_item          r_q [2];
    logic               r_q_head;
    logic [1:0]         r_q_count;

    logic               acc;
    logic               pop;
    logic               push;
    t_out_item          push_item;

    logic               tbl_we, tbl_re;
    logic [NODE_IW-1:0] tbl_waddr, tbl_raddr;
    t_node              tbl_wdata;
    t_node              tbl_rdata;
    logic               stk_we, stk_re;
    logic [STK_IW-1:0]  stk_waddr, stk_raddr;
    logic [NODE_IW-1:0] stk_wdata;
    logic [NODE_IW-1:0] stk_rdata;

    logic [STK_CW-1:0]  eff_sp;
    logic [NODE_CW-1:0] eff_nc;
    logic               eff_exp;
    logic [STK_CW-1:0]  sp_m2;
    logic [NODE_CW-1:0] nc_m1;
    logic [7:0]         byte_in;
    t_node              new_node;

    hft_ram #(.WIDTH($bits(t_node)), .DEPTH(MAX_NODES)) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_we),
        .i_wr_addr (tbl_waddr),
        .i_wr_data (tbl_wdata),
        .i_rd_en   (tbl_re),
        .i_rd_addr (tbl_raddr),
        .o_rd_data (tbl_rdata)
    );

    hft_ram #(.WIDTH(NODE_IW), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stk_we),
        .i_wr_addr (stk_waddr),
        .i_wr_data (stk_wdata),
        .i_rd_en   (stk_re),
        .i_rd_addr (stk_raddr),
        .o_rd_data (stk_rdata)
    );

    // stall only while a read is outstanding or both output slots are taken
    assign o_in_stall  = (r_pend != PEND_NONE) || (r_q_count == 2'd2);
    assign acc         = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_q_count != 2'd0);
    assign o_out_data  = r_q[r_q_head];
    assign pop         = o_out_valid && !i_out_stall;

    // a tree byte after a finished tree starts a new one
    assign eff_sp  = r_ready ? '0 : r_sp;
    assign eff_nc  = r_ready ? '0 : r_nc;
    assign eff_exp = r_ready ? 1'b0 : r_exp;
    assign sp_m2   = r_sp - STK_CW'(2);
    assign nc_m1   = r_nc - NODE_CW'(1);
    assign byte_in = i_in_data.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= PEND_NONE;
            r_sp      <= '0;
            r_nc      <= '0;
            r_exp     <= 1'b0;
            r_ready   <= 1'b0;
            r_q_head  <= 1'b0;
            r_q_count <= 2'd0;
        end else begin
            r_pend    <= n_pend;
            r_sp      <= n_sp;
            r_nc      <= n_nc;
            r_exp     <= n_exp;
            r_ready   <= n_ready;
            r_q_head  <= r_q_head ^ pop;
            r_q_count <= r_q_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        r_top  <= n_top;
        r_cur  <= n_cur;
        r_root <= n_root;
        if (push) begin
            r_q[r_q_head ^ r_q_count[0]] <= push_item;
        end
    end

    always_comb begin
        n_pend    = PEND_NONE;
        n_sp      = r_sp;
        n_nc      = r_nc;
        n_exp     = r_exp;
        n_ready   = r_ready;
        n_top     = r_top;
        n_cur     = r_cur;
        n_root    = r_root;
        push      = 1'b0;
        push_item = '{symbol: 8'd0, status: 1'b1};
        tbl_we    = 1'b0;
        tbl_waddr = eff_nc[NODE_IW-1:0];
        tbl_wdata = '0;
        tbl_re    = 1'b0;
        tbl_raddr = r_cur.left;
        stk_we    = 1'b0;
        stk_waddr = eff_sp[STK_IW-1:0];
        stk_wdata = eff_nc[NODE_IW-1:0];
        stk_re    = 1'b0;
        stk_raddr = sp_m2[STK_IW-1:0];
        new_node  = '0;

        case (r_pend)
            PEND_BRANCH: begin
                // older node from the stack read, newer is always the last node made
                new_node.leaf  = 1'b0;
                new_node.left  = stk_rdata;
                new_node.right = nc_m1[NODE_IW-1:0];
                tbl_we    = 1'b1;
                tbl_waddr = r_nc[NODE_IW-1:0];
                tbl_wdata = new_node;
                stk_we    = 1'b1;
                stk_waddr = sp_m2[STK_IW-1:0];
                stk_wdata = r_nc[NODE_IW-1:0];
                n_sp      = r_sp - STK_CW'(1);
                n_nc      = r_nc + NODE_CW'(1);
                n_top     = new_node;
            end
            PEND_CODE: begin
                if (tbl_rdata.leaf) begin
                    push      = 1'b1;
                    push_item = '{symbol: tbl_rdata.sym, status: 1'b0};
                    n_cur     = r_root;
                end else begin
                    n_cur = tbl_rdata;
                end
            end
            default: begin
                if (acc) begin
                    case (i_in_data.command)
                        CMD_TREE: begin
                            if (r_ready) begin
                                n_sp    = '0;
                                n_nc    = '0;
                                n_exp   = 1'b0;
                                n_ready = 1'b0;
                            end
                            if (eff_exp) begin
                                if (eff_nc >= NODE_CW'(MAX_NODES)
                                        || eff_sp >= STK_CW'(STACK_DEPTH)) begin
                                    push = 1'b1;
                                end else begin
                                    new_node.leaf = 1'b1;
                                    new_node.sym  = byte_in;
                                    tbl_we    = 1'b1;
                                    tbl_wdata = new_node;
                                    stk_we    = 1'b1;
                                    n_sp      = eff_sp + STK_CW'(1);
                                    n_nc      = eff_nc + NODE_CW'(1);
                                    n_exp     = 1'b0;
                                    n_top     = new_node;
                                end
                            end else if (byte_in == CH_LEAF) begin
                                n_exp = 1'b1;
                            end else if (byte_in == CH_BRANCH) begin
                                if (eff_sp < STK_CW'(2) || eff_nc >= NODE_CW'(MAX_NODES)) begin
                                    push = 1'b1;
                                end else begin
                                    stk_re = 1'b1;
                                    n_pend = PEND_BRANCH;
                                end
                            end
                        end
                        CMD_END: begin
                            n_exp = 1'b0;
                            if (r_sp == '0) begin
                                n_ready = 1'b0;
                                push    = 1'b1;
                            end else begin
                                // stack top is the last node written
                                n_root  = r_top;
                                n_cur   = r_top;
                                n_sp    = '0;
                                n_ready = 1'b1;
                            end
                        end
                        CMD_CODE: begin
                            if (byte_in == CH_ZERO || byte_in == CH_ONE) begin
                                if (!r_ready) begin
                                    push = 1'b1;
                                end else if (r_cur.leaf) begin
                                    push  = 1'b1;
                                    n_cur = r_root;
                                end else begin
                                    tbl_re    = 1'b1;
                                    tbl_raddr = (byte_in == CH_ZERO) ? r_cur.left : r_cur.right;
                                    n_pend    = PEND_CODE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

FILE: hdl/hft_checker.sv
// port-level checks for the huffman tree loader and decoder, bound to the top level
// depends on hft_pkg
module hft_checker
    import hft_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input t_in_item  i_in_data,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    // error items carry a zero symbol
    a_err_sym_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status |-> o_out_data.symbol == 8'd0)
        else $error("error item with nonzero symbol");

    // reset empties the output and frees the input
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // a memory wait ends in the next cycle when no output is waiting
    a_wait_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall && !o_out_valid |=> !o_in_stall)
        else $error("input stalled longer than one read cycle");

    // item ready for an unused command never shows up as a result by itself
    a_unused_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.command == CMD_NONE && !o_out_valid
        |=> !o_out_valid)
        else $error("result from unused command");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output item changed");

endmodule

bind huffman_tree_load_and_decode hft_checker u_hft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

FILE: tb/sv/hft_decode_check_pkg.sv
// scoreboard for the huffman tree loader and decoder: tree and walk predictor, expected queue
// depends on hft_pkg for the item types, node layout and tree/code characters
package hft_decode_check_pkg;
    import hft_pkg::*;

    class tree_decode_checker;
        t_node              nodes [MAX_NODES];
        logic [NODE_IW-1:0] node_stk [STACK_DEPTH];
        int unsigned        stk_depth;
        int unsigned        node_total;
        logic [NODE_IW-1:0] root_node;
        logic [NODE_IW-1:0] walk_node;
        bit                 literal_next;
        bit                 tree_loaded;
        t_out_item          symbols_due [$];
        int unsigned        items_seen;
        int unsigned        symbols_seen;
        int unsigned        errors_seen;
        int unsigned        trees_seen;
        int unsigned        mismatches;

        function new();
            stk_depth    = 0;
            node_total   = 0;
            root_node    = '0;
            walk_node    = '0;
            literal_next = 1'b0;
            tree_loaded  = 1'b0;
            items_seen   = 0;
            symbols_seen = 0;
            errors_seen  = 0;
            trees_seen   = 0;
            mismatches   = 0;
        endfunction

        // returns 1 when the item produces a result
        function bit decode_step(input t_in_item it, output t_out_item res);
            logic [NODE_IW-1:0] nxt;
            res = '0;
            case (it.command)
                CMD_TREE: begin
                    // a tree byte after a finished tree starts a new one
                    if (tree_loaded) begin
                        stk_depth    = 0;
                        node_total   = 0;
                        literal_next = 1'b0;
                        tree_loaded  = 1'b0;
                    end
                    if (literal_next) begin
                        if (node_total >= MAX_NODES || stk_depth >= STACK_DEPTH) begin
                            res.status = 1'b1;
                            return 1'b1;
                        end
                        nodes[node_total] = '{leaf: 1'b1, sym: it.data, left: '0, right: '0};
                        node_stk[stk_depth] = NODE_IW'(node_total);
                        stk_depth++;
                        node_total++;
                        literal_next = 1'b0;
                        return 1'b0;
                    end
                    if (it.data == CH_LEAF) begin
                        literal_next = 1'b1;
                        return 1'b0;
                    end
                    if (it.data == CH_BRANCH) begin
                        if (stk_depth < 2 || node_total >= MAX_NODES) begin
                            res.status = 1'b1;
                            return 1'b1;
                        end
                        // older node goes left
                        nodes[node_total] = '{leaf: 1'b0, sym: 8'h00,
                                              left: node_stk[stk_depth-2],
                                              right: node_stk[stk_depth-1]};
                        stk_depth -= 2;
                        node_stk[stk_depth] = NODE_IW'(node_total);
                        stk_depth++;
                        node_total++;
                    end
                    return 1'b0;
                end
                CMD_END: begin
                    literal_next = 1'b0;
                    if (stk_depth == 0) begin
                        tree_loaded = 1'b0;
                        res.status  = 1'b1;
                        return 1'b1;
                    end
                    root_node   = node_stk[stk_depth-1];
                    walk_node   = root_node;
                    stk_depth   = 0;
                    tree_loaded = 1'b1;
                    trees_seen++;
                    return 1'b0;
                end
                CMD_CODE: begin
                    if (it.data != CH_ZERO && it.data != CH_ONE)
                        return 1'b0;
                    if (!tree_loaded || nodes[walk_node].leaf) begin
                        // no tree, or a step off a lone leaf
                        if (tree_loaded)
                            walk_node = root_node;
                        res.status = 1'b1;
                        return 1'b1;
                    end
                    nxt = (it.data == CH_ZERO) ? nodes[walk_node].left : nodes[walk_node].right;
                    walk_node = nxt;
                    if (nodes[nxt].leaf) begin
                        walk_node  = root_node;
                        res.symbol = nodes[nxt].sym;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void note_item(t_in_item it);
            t_out_item res;
            items_seen++;
            if (decode_step(it, res)) begin
                symbols_due.push_back(res);
                if (res.status)
                    errors_seen++;
                else
                    symbols_seen++;
            end
        endfunction

        task report(string msg);
            if (mismatches < 40)
                $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (symbols_due.size() == 0) begin
                report($sformatf("result symbol %02h status %0d with nothing pending",
                                 got.symbol, got.status));
                return;
            end
            want = symbols_due.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.symbol !== want.symbol)
                report($sformatf("symbol %02h, want %02h", got.symbol, want.symbol));
        endtask
    endclass

endpackage

FILE: tb/sv/tb_huffman_tree_load_and_decode.sv
// top testbench for huffman_tree_load_and_decode: directed and random tree/code items
// depends on hft_pkg, hft_decode_check_pkg and the block itself
module tb_huffman_tree_load_and_decode;
    timeunit 1ns;
    timeprecision 1ps;

    import hft_pkg::*;
    import hft_decode_check_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned MAX_GAP      = 13;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      out_stall = 1'b0;

    bit          quiet_gaps   = 1'b0;
    bit          hold_req     = 1'b0;
    int unsigned useful_items = 0;
    int unsigned cycle_count  = 0;

    tree_decode_checker chk = new();

    huffman_tree_load_and_decode i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("huffman_tree_load_and_decode test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall)
            chk.check_result(out_data);
    end

    // output side: random stall before each result, plus the long hold-off on request
    initial begin : receiver
        int unsigned hold_off;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            hold_off = quiet_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_off != 0) begin
                out_stall <= 1'b1;
                repeat (hold_off) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    task automatic send_item(input t_cmd cmd, input logic [7:0] b);
        int unsigned gap;
        gap = quiet_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{command: cmd, data: b};
        do @(posedge i_clk); while (in_stall);
        chk.note_item(in_data);
        if (cmd != CMD_NONE && !(cmd == CMD_CODE && b != CH_ZERO && b != CH_ONE))
            useful_items++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (chk.symbols_due.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned leaves;
        int unsigned on_stack;
        int unsigned bits;
        int unsigned pick;
        int unsigned seq;
        int unsigned base;
        bit          held;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner cases
        send_item(CMD_CODE, CH_ZERO);      // code with no tree loaded
        send_item(CMD_END, 8'hFF);         // end of tree on an empty stack
        send_item(CMD_NONE, CH_ONE);
        send_item(CMD_TREE, 8'h00);        // stray tree byte
        send_item(CMD_TREE, CH_LEAF);
        send_item(CMD_TREE, 8'hFF);
        send_item(CMD_END, 8'h00);         // single leaf tree
        send_item(CMD_CODE, CH_ONE);       // no child below a lone leaf
        send_item(CMD_CODE, 8'hFF);        // unknown code byte
        send_item(CMD_TREE, CH_BRANCH);    // starts new tree, stack underflow
        send_item(CMD_TREE, CH_LEAF);
        send_item(CMD_TREE, 8'h00);
        send_item(CMD_TREE, CH_LEAF);
        send_item(CMD_TREE, CH_LEAF);      // leaf whose symbol is the leaf marker
        send_item(CMD_TREE, CH_LEAF);
        send_item(CMD_TREE, CH_BRANCH);
        send_item(CMD_TREE, CH_BRANCH);
        send_item(CMD_TREE, CH_LEAF);      // literal still pending at end
        send_item(CMD_END, 8'h5A);         // extra leaf under the root is dropped
        send_item(CMD_CODE, CH_ZERO);
        send_item(CMD_CODE, CH_ONE);
        wait_for_results();

        // fill the node stack with leaves, then overflow it
        repeat (STACK_DEPTH) begin
            send_item(CMD_TREE, CH_LEAF);
            send_item(CMD_TREE, 8'($urandom_range(0, 255)));
        end
        send_item(CMD_TREE, CH_LEAF);
        send_item(CMD_TREE, 8'h11);
        send_item(CMD_TREE, 8'h22);        // literal still pending after the overflow
        send_item(CMD_END, 8'h00);
        send_item(CMD_CODE, CH_ZERO);
        wait_for_results();

        // chain of branches until the node table is full
        send_item(CMD_TREE, CH_LEAF);
        send_item(CMD_TREE, 8'($urandom_range(0, 255)));
        repeat ((MAX_NODES - 2) / 2) begin
            send_item(CMD_TREE, CH_LEAF);
            send_item(CMD_TREE, 8'($urandom_range(0, 255)));
            send_item(CMD_TREE, CH_BRANCH);
        end
        send_item(CMD_TREE, CH_LEAF);
        send_item(CMD_TREE, 8'($urandom_range(0, 255)));
        send_item(CMD_TREE, CH_BRANCH);
        send_item(CMD_TREE, CH_LEAF);
        send_item(CMD_TREE, 8'h33);
        send_item(CMD_END, 8'h00);
        send_item(CMD_CODE, CH_ONE);
        wait_for_results();

        // random trees followed by code streams, with some noise and broken input
        base = useful_items;
        seq  = 0;
        while (useful_items - base < RANDOM_ITEMS) begin
            seq++;
            held = (seq == 4 || seq == 10);
            quiet_gaps = held || ($urandom_range(0, 3) == 0);
            if (held)
                hold_req = 1'b1;
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(3, 10)) begin
                    pick = $urandom_range(0, 5);
                    send_item(t_cmd'($urandom_range(0, 3)),
                              pick == 0 ? CH_LEAF : pick == 1 ? CH_BRANCH :
                              pick == 2 ? CH_ZERO : pick == 3 ? CH_ONE :
                              8'($urandom_range(0, 255)));
                end
            end else begin
                leaves   = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
                on_stack = 0;
                while (leaves != 0 || on_stack > 1) begin
                    if (leaves != 0 && (on_stack < 2 || $urandom_range(0, 1) == 1)) begin
                        send_item(CMD_TREE, CH_LEAF);
                        send_item(CMD_TREE, 8'($urandom_range(0, 255)));
                        leaves--;
                        on_stack++;
                    end else begin
                        send_item(CMD_TREE, CH_BRANCH);
                        on_stack--;
                    end
                end
                send_item(CMD_END, 8'($urandom_range(0, 255)));
            end
            bits = held ? 80 : $urandom_range(8, 40);
            repeat (bits) begin
                pick = $urandom_range(0, 24);
                if (pick == 0)
                    send_item(CMD_CODE, 8'($urandom_range(0, 255)));
                else if (pick == 1)
                    send_item(CMD_NONE, 8'($urandom_range(0, 255)));
                else if (pick == 2 && $urandom_range(0, 3) == 0)
                    send_item(CMD_END, 8'($urandom_range(0, 255)));
                else
                    send_item(CMD_CODE, $urandom_range(0, 1) ? CH_ONE : CH_ZERO);
            end
            if ($urandom_range(0, 7) == 0)
                wait_for_results();
        end

        quiet_gaps = 1'b0;
        wait_for_results();
        repeat (20) @(posedge i_clk);

        $display("covered %0d items: %0d trees loaded, %0d symbols, %0d error results",
                 chk.items_seen, chk.trees_seen, chk.symbols_seen, chk.errors_seen);
        $display("including full stack, full table and long output hold-offs");
        if (chk.mismatches == 0)
            $display("huffman_tree_load_and_decode test passed");
        else
            $display("huffman_tree_load_and_decode test failed");
        $finish;
    end

endmodule

FILE: huffman_tree_load_and_decode.f
hdl/hft_pkg.sv
hdl/hft_ram.sv
hdl/huffman_tree_load_and_decode.sv
hdl/hft_checker.sv
tb/sv/hft_decode_check_pkg.sv
tb/sv/tb_huffman_tree_load_and_decode.sv
